/* design/bli_pkg.sv */
// Shared types and codes for the byte list block.
package bli_pkg;

    typedef enum logic [3:0] {
        CMD_PUSH   = 4'd0,
        CMD_POP    = 4'd1,
        CMD_SET    = 4'd2,
        CMD_READ   = 4'd3,
        CMD_INSERT = 4'd4,
        CMD_DELETE = 4'd5,
        CMD_SEARCH = 4'd6,
        CMD_CLEAR  = 4'd7,
        CMD_FIRST  = 4'd8,
        CMD_LAST   = 4'd9
    } cmd_t;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    typedef enum logic [1:0] {
        C_HOLD,
        C_WRITE,
        C_INSERT,
        C_DELETE
    } cell_op_t;

    typedef struct packed {
        cell_op_t   op;
        logic [7:0] val;
    } cell_ctrl_t;

endpackage

/* design/bli_cell.sv */
// One storage cell of the list row: holds one byte, shifts with its neighbors.
module bli_cell #(
    parameter int AW  = 8,
    parameter int POS = 0
) (
    input  logic               clk,
    input  bli_pkg::cell_ctrl_t ctrl,
    input  logic [AW-1:0]      addr,
    input  logic [7:0]         left,
    input  logic [7:0]         right,
    output logic [7:0]         data
);

    logic [7:0]    data_reg;
    logic [7:0]    data_next;
    logic [AW-1:0] pos;

    assign pos = AW'(POS);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            bli_pkg::C_WRITE:
            begin
                if (pos == addr)
                begin
                    data_next = ctrl.val;
                end
            end
            bli_pkg::C_INSERT:
            begin
                if (pos == addr)
                begin
                    data_next = ctrl.val;
                end
                else if (pos > addr)
                begin
                    data_next = left;
                end
            end
            bli_pkg::C_DELETE:
            begin
                if (pos >= addr)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* design/bli_tree.sv */
// Registered OR tree over the cell row for indexed reads and value search.
module bli_tree #(
    parameter int CAPACITY = 256,
    parameter int AW       = 8,
    parameter int CW       = 9
) (
    input  logic                       clk,
    input  logic [CAPACITY-1:0][7:0]   cells,
    input  logic                       search,
    input  logic [7:0]                 key,
    input  logic [AW-1:0]              sel,
    input  logic [CW-1:0]              count,
    output logic                       hit,
    output logic [7:0]                 dat
);

    localparam int P = 1 << AW;

    logic       hit_reg [2*P-1];
    logic [7:0] dat_reg [2*P-1];

    genvar i;
    generate
        for (i = 0; i < P - 1; i++)
        begin : g_node
            always_ff @(posedge clk)
            begin
                hit_reg[i] <= hit_reg[2*i+1] | hit_reg[2*i+2];
                dat_reg[i] <= dat_reg[2*i+1] | dat_reg[2*i+2];
            end
        end
        for (i = 0; i < P; i++)
        begin : g_leaf
            if (i < CAPACITY)
            begin : g_used
                logic sel_hit;
                assign sel_hit = !search && (AW'(i) == sel);
                always_ff @(posedge clk)
                begin
                    hit_reg[P-1+i] <= search ? ((cells[i] == key) && (CW'(i) < count))
                                             : sel_hit;
                    dat_reg[P-1+i] <= sel_hit ? cells[i] : 8'd0;
                end
            end
            else
            begin : g_pad
                always_ff @(posedge clk)
                begin
                    hit_reg[P-1+i] <= 1'b0;
                    dat_reg[P-1+i] <= 8'd0;
                end
            end
        end
    endgenerate

    assign hit = hit_reg[0];
    assign dat = dat_reg[0];

endmodule

/* design/byte_list_insert_delete_search.sv */
// Byte list top level: a row of cells that shift on insert and delete.
// Push, pop, set, insert, delete, clear and rejected words: done in the cycle after start,
// one word per cycle while no scan is running.
// Valid read, first and last, and search pass a registered OR tree over the row: done comes
// once the leaf registers and then each tree level have loaded, busy high until then.
// Reset clears the entry count and control; cell contents are not reset.
module byte_list_insert_delete_search #(
    parameter int CAPACITY = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [3:0] cmd,
    input  logic [7:0] index,
    input  logic [7:0] value,
    output logic       done,
    output logic [7:0] read_data,
    output logic       found,
    output logic [1:0] status,
    output logic [8:0] count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > 8) ? CW : 8;
    localparam int SW = $clog2(AW + 2);

    bli_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [SW-1:0]   cnt_reg, cnt_next;
    logic            srch_reg, srch_next;
    logic [7:0]      key_reg, key_next;
    logic [AW-1:0]   sel_reg, sel_next;
    logic            done_reg, done_next;
    logic [7:0]      rd_reg, rd_next;
    logic            found_reg, found_next;
    logic [1:0]      st_reg, st_next;

    bli_pkg::cell_ctrl_t      ctrl;
    logic [AW-1:0]            addr;
    logic [CAPACITY-1:0][7:0] cells;
    logic                     tree_hit;
    logic [7:0]               tree_dat;

    logic in_range;
    logic empty;
    logic full;

    assign in_range = XW'(index) < XW'(count_reg);
    assign empty    = count_reg == '0;
    assign full     = count_reg == CW'(CAPACITY);

    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++)
        begin : g_cell
            logic [7:0] left_d;
            logic [7:0] right_d;
            if (k == 0)
            begin : g_first
                assign left_d = 8'd0;
            end
            else
            begin : g_mid_l
                assign left_d = cells[k-1];
            end
            if (k == CAPACITY - 1)
            begin : g_last
                assign right_d = cells[k];
            end
            else
            begin : g_mid_r
                assign right_d = cells[k+1];
            end
            bli_cell #(
                .AW  (AW),
                .POS (k)
            ) u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .addr  (addr),
                .left  (left_d),
                .right (right_d),
                .data  (cells[k])
            );
        end
    endgenerate

    bli_tree #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_tree (
        .clk    (clk),
        .cells  (cells),
        .search (srch_reg),
        .key    (key_reg),
        .sel    (sel_reg),
        .count  (count_reg),
        .hit    (tree_hit),
        .dat    (tree_dat)
    );

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        cnt_next   = cnt_reg;
        srch_next  = srch_reg;
        key_next   = key_reg;
        sel_next   = sel_reg;
        done_next  = 1'b0;
        rd_next    = rd_reg;
        found_next = found_reg;
        st_next    = st_reg;
        ctrl.op    = bli_pkg::C_HOLD;
        ctrl.val   = value;
        addr       = AW'(index);
        case (state_reg)
            bli_pkg::S_IDLE:
            begin
                if (start)
                begin
                    done_next  = 1'b1;
                    rd_next    = 8'd0;
                    found_next = 1'b0;
                    st_next    = bli_pkg::ST_DONE;
                    case (cmd)
                        bli_pkg::CMD_PUSH:
                        begin
                            if (full)
                            begin
                                st_next = bli_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.op    = bli_pkg::C_WRITE;
                                addr       = AW'(count_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bli_pkg::CMD_POP:
                        begin
                            if (empty)
                            begin
                                st_next = bli_pkg::ST_RANGE;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bli_pkg::CMD_SET:
                        begin
                            if (!in_range)
                            begin
                                st_next = bli_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ctrl.op = bli_pkg::C_WRITE;
                            end
                        end
                        bli_pkg::CMD_READ:
                        begin
                            if (!in_range)
                            begin
                                st_next = bli_pkg::ST_RANGE;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = bli_pkg::S_SCAN;
                                cnt_next   = '0;
                                srch_next  = 1'b0;
                                sel_next   = AW'(index);
                            end
                        end
                        bli_pkg::CMD_INSERT:
                        begin
                            if (!in_range)
                            begin
                                st_next = bli_pkg::ST_RANGE;
                            end
                            else if (full)
                            begin
                                st_next = bli_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.op    = bli_pkg::C_INSERT;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        bli_pkg::CMD_DELETE:
                        begin
                            if (!in_range)
                            begin
                                st_next = bli_pkg::ST_RANGE;
                            end
                            else
                            begin
                                ctrl.op    = bli_pkg::C_DELETE;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        bli_pkg::CMD_SEARCH:
                        begin
                            done_next  = 1'b0;
                            state_next = bli_pkg::S_SCAN;
                            cnt_next   = '0;
                            srch_next  = 1'b1;
                            key_next   = value;
                        end
                        bli_pkg::CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        bli_pkg::CMD_FIRST:
                        begin
                            if (empty)
                            begin
                                st_next = bli_pkg::ST_RANGE;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = bli_pkg::S_SCAN;
                                cnt_next   = '0;
                                srch_next  = 1'b0;
                                sel_next   = '0;
                            end
                        end
                        bli_pkg::CMD_LAST:
                        begin
                            if (empty)
                            begin
                                st_next = bli_pkg::ST_RANGE;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = bli_pkg::S_SCAN;
                                cnt_next   = '0;
                                srch_next  = 1'b0;
                                sel_next   = AW'(count_reg - 1'b1);
                            end
                        end
                        default:
                        begin
                            st_next = bli_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            bli_pkg::S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SW'(AW + 1))
                begin
                    state_next = bli_pkg::S_IDLE;
                    done_next  = 1'b1;
                    rd_next    = srch_reg ? 8'd0 : tree_dat;
                    found_next = srch_reg & tree_hit;
                    st_next    = bli_pkg::ST_DONE;
                end
            end
            default:
            begin
                state_next = bli_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bli_pkg::S_IDLE;
            count_reg <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        srch_reg  <= srch_next;
        key_reg   <= key_next;
        sel_reg   <= sel_next;
        rd_reg    <= rd_next;
        found_reg <= found_next;
        st_reg    <= st_next;
    end

    assign busy      = state_reg != bli_pkg::S_IDLE;
    assign done      = done_reg;
    assign read_data = rd_reg;
    assign found     = found_reg;
    assign status    = st_reg;
    assign count     = 9'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result word while a scan is running");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == bli_pkg::CMD_CLEAR) |=> (done && count_reg == '0))
        else $error("clear did not empty the list");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bli_pkg::ST_FULL) |-> (count_reg == CW'(CAPACITY)))
        else $error("full status with room left");

endmodule
